// ----- rtl/core/partial_shuffle_sampler_core_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the partial shuffle sampler core
// Shared property wrappers, clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef PARTIAL_SHUFFLE_SAMPLER_CORE_DEFINES_SVH
`define PARTIAL_SHUFFLE_SAMPLER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/pss_pkg.sv -----
// ---------------------------------------------------------------------------
// Partial shuffle sampler package
// Sizes, register indexes, state codes and the result type of the core.
// ---------------------------------------------------------------------------
`default_nettype none

package pss_pkg;

  localparam int unsigned MAX_POPULATION = 1024;
  localparam int unsigned IDX_W   = $clog2(MAX_POPULATION);
  localparam int unsigned CNT_W   = IDX_W + 1;
  localparam int unsigned OUT_W   = 10;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned PROD_W  = CNT_W + WORD_W;
  localparam int unsigned EPOCH_W = 8;
  localparam int unsigned RAM_W   = EPOCH_W + IDX_W;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
  localparam logic [CNT_W-1:0]   POP_MAX   = CNT_W'(MAX_POPULATION);

  localparam logic [CFG_IDX_W-1:0] CFG_POPULATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAWS      = 2'd1;

  typedef enum logic {
    ST_SWEEP,
    ST_RUN
  } pss_state_e;

  typedef struct packed {
    logic [OUT_W-1:0] chosen_index;
    logic [OUT_W-1:0] slot;
    logic             last;
  } pss_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/partial_shuffle_sampler_core.sv -----
// ---------------------------------------------------------------------------
// Partial shuffle sampler core
// Draws samples without replacement by a partial Fisher-Yates shuffle.
// ---------------------------------------------------------------------------
// Each input transfer carries one 32-bit random word and yields exactly one
// result: the chosen index, its slot in the sample and a last-of-sample flag.
// The result is registered through stages s1 and s2, written into the output
// queue from s2 and can leave once the queue holds it. A new word is not taken
// while the previous one is in stage s1, because each draw reads two entries
// of the index RAM through its single read port.
// The index RAM holds an epoch tag per entry; an entry whose tag differs from
// the current sample's epoch reads as its own index.
// After reset, and again after every 255 samples when the epoch counter
// wraps, a clearing pass writes tag zero to all 1024 entries, one a cycle;
// in_ready_o stays low during the pass. Configuration writes are taken
// at any time and restart the sample.
// A two-entry result queue decouples the output: while the receiver stalls
// the queue fills, and in_ready_o drops once no room is left for a result.
// ---------------------------------------------------------------------------
`default_nettype none

module partial_shuffle_sampler_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [pss_pkg::WORD_W-1:0]        random_word_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [pss_pkg::OUT_W-1:0]         chosen_index_o,
  output logic      [pss_pkg::OUT_W-1:0]         slot_o,
  output logic                                   last_of_sample_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [pss_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [pss_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int unsigned IDX_W   = pss_pkg::IDX_W;
  localparam int unsigned CNT_W   = pss_pkg::CNT_W;
  localparam int unsigned EPOCH_W = pss_pkg::EPOCH_W;
  localparam int unsigned RAM_W   = pss_pkg::RAM_W;
  localparam int unsigned PROD_W  = pss_pkg::PROD_W;
  localparam int unsigned WORD_W  = pss_pkg::WORD_W;

  function automatic logic [IDX_W-1:0] resolve(input logic [RAM_W-1:0]   entry,
                                               input logic [EPOCH_W-1:0] epoch,
                                               input logic [IDX_W-1:0]   addr);
    logic [IDX_W-1:0] val;
    if (entry[RAM_W-1:IDX_W] == epoch) begin
      val = entry[IDX_W-1:0];
    end else begin
      val = addr;
    end
    return val;
  endfunction

  // Control state.
  pss_pkg::pss_state_e state_q, state_d;
  logic [IDX_W-1:0]   sweep_addr_q, sweep_addr_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   pop_q, draws_q;
  logic               s1_valid_q, s2_valid_q, s3_valid_q;
  logic               byp_hit_q;

  // Stage payload.
  logic [WORD_W-1:0]  s1_word_q;
  logic [CNT_W-1:0]   s1_span_q;
  logic [IDX_W-1:0]   s1_top_q, s1_slot_q;
  logic               s1_last_q;
  logic [EPOCH_W-1:0] s1_epoch_q;
  logic [IDX_W-1:0]   s2_pos_q, s2_top_q, s2_b_q, s2_slot_q;
  logic               s2_last_q;
  logic [EPOCH_W-1:0] s2_epoch_q;
  logic [IDX_W-1:0]   s3_top_q, s3_a_q;
  logic [EPOCH_W-1:0] s3_epoch_q;
  logic [RAM_W-1:0]   byp_data_q;

  // Derived values.
  logic [CNT_W-1:0]   n_eff, s_eff, span;
  logic [IDX_W-1:0]   top, slot, pos, a_val, b_val;
  logic               last, accept, epoch_wrap, pipe_empty;
  logic [PROD_W-1:0]  prod;
  logic [2:0]         occupancy;
  logic [1:0]         fifo_cnt;

  // RAM ports.
  logic               ram_we, byp_hit_d;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [RAM_W-1:0]   ram_wdata, ram_rdata, rd_eff;

  pss_pkg::pss_result_t push_data, head;

  always_comb begin
    if (pop_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (pop_q > pss_pkg::POP_MAX) begin
      n_eff = pss_pkg::POP_MAX;
    end else begin
      n_eff = pop_q;
    end
    if (draws_q == '0) begin
      s_eff = CNT_W'(1);
    end else if (draws_q > n_eff) begin
      s_eff = n_eff;
    end else begin
      s_eff = draws_q;
    end
  end

  assign span = n_eff - {1'b0, cnt_q};
  assign top  = IDX_W'(span - CNT_W'(1));
  assign slot = IDX_W'(s_eff - CNT_W'(1) - {1'b0, cnt_q});
  assign last = (({1'b0, cnt_q} + CNT_W'(1)) == s_eff);

  assign epoch_wrap = (cnt_q == '0) && (epoch_q == pss_pkg::EPOCH_MAX);
  assign pipe_empty = !s1_valid_q && !s2_valid_q && !s3_valid_q;
  assign occupancy  = {1'b0, fifo_cnt} + {2'b00, s2_valid_q};
  assign in_ready_o = (state_q == pss_pkg::ST_RUN) && !epoch_wrap && !s1_valid_q
                      && (occupancy < 3'd2);
  assign accept     = in_valid_i && in_ready_o;

  // Swap position from the registered word: floor(span * word / 2^32).
  assign prod = PROD_W'(s1_span_q) * PROD_W'(s1_word_q);
  assign pos  = prod[IDX_W+WORD_W-1:WORD_W];

  // A write issued in the same cycle as a read to the same entry is
  // forwarded, since the RAM returns the old data.
  assign rd_eff = byp_hit_q ? byp_data_q : ram_rdata;
  assign b_val  = resolve(rd_eff, s1_epoch_q, s1_top_q);
  assign a_val  = resolve(rd_eff, s2_epoch_q, s2_pos_q);

  always_comb begin
    ram_raddr = s1_valid_q ? pos : top;
    if (state_q == pss_pkg::ST_SWEEP) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_addr_q;
      ram_wdata = '0;
    end else if (s2_valid_q) begin
      ram_we    = 1'b1;
      ram_waddr = s2_pos_q;
      ram_wdata = {s2_epoch_q, s2_b_q};
    end else begin
      ram_we    = s3_valid_q;
      ram_waddr = s3_top_q;
      ram_wdata = {s3_epoch_q, s3_a_q};
    end
    byp_hit_d = ram_we && (ram_waddr == ram_raddr);
  end

  pss_ram #(
    .WIDTH (RAM_W),
    .DEPTH (pss_pkg::MAX_POPULATION)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    sweep_addr_d = sweep_addr_q;
    epoch_d      = epoch_q;
    unique case (state_q)
      pss_pkg::ST_SWEEP: begin
        sweep_addr_d = sweep_addr_q + IDX_W'(1);
        if (sweep_addr_q == IDX_W'(pss_pkg::MAX_POPULATION - 1)) begin
          state_d = pss_pkg::ST_RUN;
          epoch_d = '0;
        end
      end
      pss_pkg::ST_RUN: begin
        if (epoch_wrap && pipe_empty) begin
          state_d = pss_pkg::ST_SWEEP;
        end else if (accept && (cnt_q == '0)) begin
          epoch_d = epoch_q + EPOCH_W'(1);
        end
      end
      default: begin
        state_d = pss_pkg::ST_SWEEP;
      end
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = last ? '0 : cnt_q + IDX_W'(1);
    end
    if (cfg_we_i && ((cfg_index_i == pss_pkg::CFG_POPULATION) ||
                     (cfg_index_i == pss_pkg::CFG_DRAWS))) begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pss_pkg::ST_SWEEP;
      sweep_addr_q <= '0;
      epoch_q      <= '0;
      cnt_q        <= '0;
      pop_q        <= pss_pkg::POP_MAX;
      draws_q      <= CNT_W'(1);
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      s3_valid_q   <= 1'b0;
      byp_hit_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      sweep_addr_q <= sweep_addr_d;
      epoch_q      <= epoch_d;
      cnt_q        <= cnt_d;
      if (cfg_we_i && (cfg_index_i == pss_pkg::CFG_POPULATION)) begin
        pop_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_index_i == pss_pkg::CFG_DRAWS)) begin
        draws_q <= cfg_data_i;
      end
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      byp_hit_q  <= byp_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= ram_wdata;
    if (accept) begin
      s1_word_q  <= random_word_i;
      s1_span_q  <= span;
      s1_top_q   <= top;
      s1_slot_q  <= slot;
      s1_last_q  <= last;
      s1_epoch_q <= (cnt_q == '0) ? epoch_q + EPOCH_W'(1) : epoch_q;
    end
    if (s1_valid_q) begin
      s2_pos_q   <= pos;
      s2_top_q   <= s1_top_q;
      s2_b_q     <= b_val;
      s2_slot_q  <= s1_slot_q;
      s2_last_q  <= s1_last_q;
      s2_epoch_q <= s1_epoch_q;
    end
    if (s2_valid_q) begin
      s3_top_q   <= s2_top_q;
      s3_a_q     <= a_val;
      s3_epoch_q <= s2_epoch_q;
    end
  end

  always_comb begin
    push_data.chosen_index = a_val;
    push_data.slot         = s2_slot_q;
    push_data.last         = s2_last_q;
  end

  pss_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s2_valid_q),
    .data_i  (push_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (head),
    .count_o (fifo_cnt)
  );

  assign chosen_index_o   = head.chosen_index;
  assign slot_o           = head.slot;
  assign last_of_sample_o = head.last;

endmodule

`default_nettype wire

// ----- rtl/core/pss_ram.sv -----
// ---------------------------------------------------------------------------
// Generic two-port RAM
// One write port and one read port with a registered read (old data on a
// same-address collision).
// ---------------------------------------------------------------------------
`default_nettype none

module pss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/core/pss_out_fifo.sv -----
// ---------------------------------------------------------------------------
// Result queue
// Two-entry queue between the draw pipeline and the output channel.
// ---------------------------------------------------------------------------
`default_nettype none

module pss_out_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire pss_pkg::pss_result_t data_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output pss_pkg::pss_result_t     data_o,
  output logic [1:0]               count_o
);

  pss_pkg::pss_result_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign valid_o = (count_q != 2'd0);
  assign pop     = valid_o && ready_i;
  assign data_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pss_checker.sv -----
// ---------------------------------------------------------------------------
// Partial shuffle sampler port checker
// Watches the core's ports over time; bound into partial_shuffle_sampler_core.
// ---------------------------------------------------------------------------
`default_nettype none

`include "partial_shuffle_sampler_core_defines.svh"

module pss_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [pss_pkg::OUT_W-1:0]     chosen_index_o,
  input wire logic [pss_pkg::OUT_W-1:0]     slot_o,
  input wire logic                          last_of_sample_o
);

  // A stalled result keeps its payload.
  `PSS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(chosen_index_o) && $stable(slot_o) && $stable(last_of_sample_o),
    "stalled result changed")

  // The last draw of a sample always lands in slot zero and only there.
  `PSS_ASSERT_SAME(a_last_slot, out_valid_o,
    last_of_sample_o == (slot_o == '0), "last flag disagrees with slot")

  // The store's read port is busy in the cycle after a transfer.
  `PSS_ASSERT_NEXT(a_two_cycle, in_valid_i && in_ready_o, !in_ready_o,
    "input taken in two consecutive cycles")

  // The clearing pass after reset keeps the input closed.
  `PSS_ASSERT_SAME(a_reset_sweep, $rose(rst_ni), !in_ready_o,
    "input ready during the clearing pass")

endmodule

bind partial_shuffle_sampler_core pss_checker u_pss_checker (.*);

`default_nettype wire
